### rtl/core/fbfl_pkg.sv
// shared constants, codes and types of the fixed block free list allocator
package fbfl_pkg;

   // pool geometry
   localparam int MAX_BLOCKS   = 256;
   localparam int HEADER_BYTES = 4;

   // widths that follow from the pool size
   localparam int ADDR_W = $clog2(MAX_BLOCKS);
   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);

   // field and register widths
   localparam int OP_W      = 2;
   localparam int OFF_W     = 21;
   localparam int SLOT_W    = 9;
   localparam int BLK_W     = 9;
   localparam int DATA_W    = 13;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;

   // stride and derived arithmetic widths
   localparam int STRIDE_W = DATA_W + 1;
   localparam int LIM_W    = LINK_W + STRIDE_W;
   localparam int PROD_W   = LINK_W + STRIDE_W;

   // request opcodes
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_STATUS = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA   = 1'b1;

   // register reset values
   localparam logic [BLK_W-1:0]  BLOCKS_RESET = 9'd256;
   localparam logic [DATA_W-1:0] DATA_RESET   = 13'd60;

   // result of the free offset check
   typedef struct packed {
      logic              done;
      logic              hit;
      logic [ADDR_W-1:0] index;
   } fbfl_chk_type;

endpackage

### rtl/core/fixed_block_free_list_allocator_core.sv
// top level of the fixed block free list allocator
//
// pool of equal blocks chained as a free list through a link ram
// request channel (req_valid/req_ready): opcode and offset to free
//   allocate pops the head block and returns its data offset
//   free checks the offset and pushes the block back on the list
//   clear relinks blocks 0..n-1 in order, status only reports
// response channel (rsp_valid/rsp_ready): ok, block offset, full/empty, free slots
// one request in flight at a time; req_ready is high while idle
// steps from accept to response valid:
//   status and clear respond directly; allocate: link ram read, then multiply
//   free: limit multiply, range test, then the iterative divider at one quotient
//   bit per cycle for log2(MAX_BLOCKS) bits, skipped when the range test fails
// the response register holds its result while the receiver stalls; a new
// request is accepted meanwhile, and its result waits until the slot frees
// reset: link ram reads as i+1 through per-entry valid bits, head and count zero, no
// clearing pass; config write port is plain; user writes idle only, unenforced
module fixed_block_free_list_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fbfl_pkg::OP_W-1:0]       req_opcode,
   input  logic [fbfl_pkg::OFF_W-1:0]      req_free_offset,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic [fbfl_pkg::OFF_W-1:0]      rsp_block_offset,
   output logic                            rsp_pool_full,
   output logic                            rsp_pool_empty,
   output logic [fbfl_pkg::SLOT_W-1:0]     rsp_free_slots,
   // configuration write port
   input  logic                            csr_we,
   input  logic [fbfl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbfl_pkg::CSR_W-1:0]      csr_wdata
);
   import fbfl_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ALLOC = 2'd1;
   localparam logic [1:0] S_FREE  = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   localparam logic [LINK_W-1:0] MAX_N = LINK_W'(MAX_BLOCKS);

   // control and list state
   logic [1:0]            state_ff, state_in;
   logic [LINK_W-1:0]     head_ff,  head_in;
   logic [LINK_W-1:0]     cnt_ff,   cnt_in;
   logic [MAX_BLOCKS-1:0] valid_ff, valid_in;
   logic [OP_W-1:0]       op_ff,    op_in;
   logic                  ok_ff,    ok_in;
   logic [PROD_W-1:0]     prod_ff,  prod_in;

   // configuration registers
   logic [BLK_W-1:0]      blocks_ff, blocks_in;
   logic [DATA_W-1:0]     data_ff,   data_in;

   // response register
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic                  rsp_ok_ff,     rsp_ok_in;
   logic [OFF_W-1:0]      rsp_off_ff,    rsp_off_in;
   logic                  rsp_full_ff,   rsp_full_in;
   logic                  rsp_empty_ff,  rsp_empty_in;
   logic [SLOT_W-1:0]     rsp_slots_ff,  rsp_slots_in;

   // datapath
   logic [LINK_W-1:0]     n_w;
   logic [STRIDE_W-1:0]   stride_w;
   logic                  pool_full_w;
   logic                  ram_re;
   logic                  ram_we;
   logic [LINK_W-1:0]     ram_rdata;
   logic                  chk_start;
   fbfl_chk_type          chk;

   // block count saturated at capacity, stride is data plus header
   assign n_w      = (32'(blocks_ff) > 32'(MAX_BLOCKS)) ? MAX_N : LINK_W'(blocks_ff);
   assign stride_w = STRIDE_W'(data_ff) + STRIDE_W'(HEADER_BYTES);
   assign pool_full_w = (cnt_ff >= n_w);

   // next-link memory, unwritten entries read through valid bits as i+1
   fbfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (chk.index),
      .wdata (head_ff),
      .re    (ram_re),
      .raddr (head_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   // offset range and stride check for free requests
   fbfl_free_check u_free_check (
      .clock    (clock),
      .reset    (reset),
      .start    (chk_start),
      .offset   (req_free_offset),
      .n_blocks (n_w),
      .stride   (stride_w),
      .result   (chk)
   );

   // configuration writes
   always_comb begin
      blocks_in = blocks_ff;
      data_in   = data_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCKS: blocks_in = csr_wdata[BLK_W-1:0];
            CSR_DATA:   data_in   = csr_wdata[DATA_W-1:0];
         endcase
      end
   end

   // request sequencer
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      valid_in  = valid_ff;
      op_in     = op_ff;
      ok_in     = ok_ff;
      prod_in   = prod_ff;
      ram_re    = 1'b0;
      ram_we    = 1'b0;
      chk_start = 1'b0;

      // response slot drains when taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_slots_in = rsp_slots_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               ok_in = 1'b0;
               unique case (req_opcode)
                  OP_ALLOC: begin
                     // fetch the link of the current head
                     ram_re   = 1'b1;
                     state_in = S_ALLOC;
                  end
                  OP_FREE: begin
                     chk_start = 1'b1;
                     state_in  = S_FREE;
                  end
                  OP_CLEAR: begin
                     // blocks below n fall back to their reset link
                     for (int i = 0; i < MAX_BLOCKS; i++) begin
                        if (LINK_W'(i) < n_w) begin
                           valid_in[i] = 1'b0;
                        end
                     end
                     head_in  = '0;
                     cnt_in   = '0;
                     ok_in    = 1'b1;
                     state_in = S_RESP;
                  end
                  OP_STATUS: begin
                     ok_in    = 1'b1;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // fails when exhausted or the head lies beyond the pool
            if (!pool_full_w && (head_ff < n_w)) begin
               ok_in   = 1'b1;
               prod_in = PROD_W'(head_ff) * PROD_W'(stride_w);
               head_in = valid_ff[head_ff[ADDR_W-1:0]] ? ram_rdata
                                                       : head_ff + LINK_W'(1);
               cnt_in  = cnt_ff + LINK_W'(1);
            end
            state_in = S_RESP;
         end
         S_FREE: begin
            if (chk.done) begin
               ok_in = chk.hit;
               if (chk.hit) begin
                  // push the block, count saturates at zero
                  ram_we              = 1'b1;
                  valid_in[chk.index] = 1'b1;
                  head_in             = LINK_W'(chk.index);
                  cnt_in              = (cnt_ff == '0) ? '0 : cnt_ff - LINK_W'(1);
               end
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_off_in   = (ok_ff && (op_ff == OP_ALLOC))
                              ? OFF_W'(prod_ff + PROD_W'(HEADER_BYTES)) : '0;
               rsp_full_in  = pool_full_w;
               rsp_empty_in = (cnt_ff == '0);
               rsp_slots_in = pool_full_w ? '0 : SLOT_W'(n_w - cnt_ff);
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         blocks_ff    <= BLOCKS_RESET;
         data_ff      <= DATA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         blocks_ff    <= blocks_in;
         data_ff      <= data_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      ok_ff        <= ok_in;
      prod_ff      <= prod_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_slots_ff <= rsp_slots_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_pool_full    = rsp_full_ff;
   assign rsp_pool_empty   = rsp_empty_ff;
   assign rsp_free_slots   = rsp_slots_ff;

`ifndef SYNTH
   // an accepted request always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted request did not start");

   // the allocated count never passes capacity
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_N)
      else $error("allocated count beyond capacity");

   // a failed request never reports an offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_off_ff == '0)
      else $error("failed request with nonzero offset");

   // the free check only finishes while a free is outstanding
   a_chk_owner: assert property (@(posedge clock) disable iff (reset)
      chk.done |-> state_ff == S_FREE)
      else $error("free check finished outside a free");
`endif

endmodule

### rtl/core/fbfl_ram.sv
// generic single write port ram with registered read
module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/fbfl_free_check.sv
// iterative check of a freed offset: range test and restoring division by the stride
module fbfl_free_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fbfl_pkg::OFF_W-1:0]     offset,
   input  logic [fbfl_pkg::LINK_W-1:0]    n_blocks,
   input  logic [fbfl_pkg::STRIDE_W-1:0]  stride,
   output fbfl_pkg::fbfl_chk_type         result
);
   import fbfl_pkg::*;

   localparam int BIT_W = (ADDR_W > 1) ? $clog2(ADDR_W) : 1;
   localparam int DIV_W = (OFF_W > STRIDE_W + ADDR_W) ? OFF_W : STRIDE_W + ADDR_W;
   localparam int CMP_W = (OFF_W > LIM_W) ? OFF_W : LIM_W;

   localparam logic [2:0] CK_IDLE  = 3'd0;
   localparam logic [2:0] CK_LIMIT = 3'd1;
   localparam logic [2:0] CK_TEST  = 3'd2;
   localparam logic [2:0] CK_DIV   = 3'd3;
   localparam logic [2:0] CK_DONE  = 3'd4;

   logic [2:0]        st_ff,  st_in;
   logic [OFF_W-1:0]  rem_ff, rem_in;
   logic [ADDR_W-1:0] quo_ff, quo_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [LIM_W-1:0]  lim_ff, lim_in;
   logic              low_ff, low_in;
   logic              hit_ff, hit_in;

   logic [DIV_W-1:0]  rem_x;
   logic [DIV_W-1:0]  div_x;
   logic              ge;
   logic [OFF_W-1:0]  rem_next;

   // one quotient bit per cycle
   assign rem_x    = DIV_W'(rem_ff);
   assign div_x    = DIV_W'(stride) << bit_ff;
   assign ge       = (rem_x >= div_x);
   assign rem_next = ge ? OFF_W'(rem_x - div_x) : rem_ff;

   always_comb begin
      st_in  = st_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      bit_in = bit_ff;
      lim_in = lim_ff;
      low_in = low_ff;
      hit_in = hit_ff;
      unique case (st_ff)
         CK_IDLE: begin
            if (start) begin
               low_in = (offset < OFF_W'(HEADER_BYTES));
               rem_in = offset - OFF_W'(HEADER_BYTES);
               quo_in = '0;
               st_in  = CK_LIMIT;
            end
         end
         CK_LIMIT: begin
            lim_in = LIM_W'(n_blocks) * LIM_W'(stride);
            st_in  = CK_TEST;
         end
         CK_TEST: begin
            bit_in = BIT_W'(ADDR_W - 1);
            if (low_ff || (CMP_W'(rem_ff) >= CMP_W'(lim_ff))) begin
               hit_in = 1'b0;
               st_in  = CK_DONE;
            end else begin
               st_in  = CK_DIV;
            end
         end
         CK_DIV: begin
            rem_in = rem_next;
            if (ge) begin
               quo_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               hit_in = (rem_next == '0);
               st_in  = CK_DONE;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         CK_DONE: begin
            st_in = CK_IDLE;
         end
         default: begin
            st_in = CK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CK_IDLE;
      end else begin
         st_ff <= st_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      lim_ff <= lim_in;
      low_ff <= low_in;
      hit_ff <= hit_in;
   end

   assign result.done  = (st_ff == CK_DONE);
   assign result.hit   = hit_ff;
   assign result.index = quo_ff;

endmodule

### tb/sv/pool_reply_checker.sv
// request/response checker with its own free list predictor for the block allocator
`timescale 1ns / 100ps

module pool_reply_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [fbfl_pkg::OP_W-1:0]      req_opcode,
   input  logic [fbfl_pkg::OFF_W-1:0]     req_free_offset,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_ok,
   input  logic [fbfl_pkg::OFF_W-1:0]     rsp_block_offset,
   input  logic                           rsp_pool_full,
   input  logic                           rsp_pool_empty,
   input  logic [fbfl_pkg::SLOT_W-1:0]    rsp_free_slots,
   input  logic                           csr_we,
   input  logic [fbfl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbfl_pkg::CSR_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);
   import fbfl_pkg::*;

   typedef struct packed {
      logic              ok;
      logic [OFF_W-1:0]  block_offset;
      logic              pool_full;
      logic              pool_empty;
      logic [SLOT_W-1:0] free_slots;
   } pool_reply_type;

   // predicted pool state
   logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
   logic [LINK_W-1:0] head_idx;
   logic [LINK_W-1:0] used_count;
   logic [BLK_W-1:0]  blocks_cfg;
   logic [DATA_W-1:0] data_cfg;

   pool_reply_type pending_replies [$];

   function automatic void relink_blocks(input int unsigned n);
      for (int unsigned i = 0; i < n && i < MAX_BLOCKS; i++)
         link_mem[i] = LINK_W'(i + 1);
      head_idx = '0;
   endfunction

   function automatic pool_reply_type serve_pool_request(input logic [OP_W-1:0]  op,
                                                         input logic [OFF_W-1:0] off);
      int unsigned      n;
      longint unsigned  stride;
      longint unsigned  span;
      longint unsigned  k;
      pool_reply_type   r;
      n      = (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
      stride = longint'(data_cfg) + HEADER_BYTES;
      r      = '0;
      case (op)
         OP_ALLOC: begin
            if (used_count < n && head_idx < n) begin
               r.block_offset = OFF_W'(longint'(head_idx) * stride + HEADER_BYTES);
               head_idx       = link_mem[head_idx];
               used_count     = used_count + 1'b1;
               r.ok           = 1'b1;
            end
         end
         OP_FREE: begin
            if (off >= HEADER_BYTES) begin
               span = longint'(off) - HEADER_BYTES;
               if (span % stride == 0) begin
                  k = span / stride;
                  if (k < n) begin
                     link_mem[k] = head_idx;
                     head_idx    = LINK_W'(k);
                     // a repeated free of the same block is not caught
                     if (used_count > 0)
                        used_count = used_count - 1'b1;
                     r.ok = 1'b1;
                  end
               end
            end
         end
         OP_CLEAR: begin
            relink_blocks(n);
            used_count = '0;
            r.ok       = 1'b1;
         end
         default: r.ok = 1'b1;
      endcase
      r.pool_full  = (used_count >= n);
      r.pool_empty = (used_count == 0);
      r.free_slots = (used_count >= n) ? '0 : SLOT_W'(n - used_count);
      return r;
   endfunction

   always @(posedge clock) begin
      pool_reply_type want;
      pool_reply_type got;
      int             errs;
      errs = 0;
      if (reset) begin
         blocks_cfg = BLOCKS_RESET;
         data_cfg   = DATA_RESET;
         relink_blocks(MAX_BLOCKS);
         used_count = '0;
         pending_replies.delete();
         outstanding <= 0;
         fail_count  <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCKS: blocks_cfg = csr_wdata[BLK_W-1:0];
               CSR_DATA:   data_cfg   = csr_wdata[DATA_W-1:0];
               default:    ;
            endcase
         end
         if (req_valid && req_ready)
            pending_replies.push_back(serve_pool_request(req_opcode, req_free_offset));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_ok, rsp_block_offset, rsp_pool_full, rsp_pool_empty, rsp_free_slots};
            if (pending_replies.size() == 0) begin
               $error("response with no request pending");
               errs++;
            end else begin
               want = pending_replies.pop_front();
               if (got.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, got.ok);
                  errs++;
               end
               if (got.block_offset !== want.block_offset) begin
                  $error("block_offset: expected %0d, got %0d",
                         want.block_offset, got.block_offset);
                  errs++;
               end
               if (got.pool_full !== want.pool_full) begin
                  $error("pool_full: expected %0d, got %0d", want.pool_full, got.pool_full);
                  errs++;
               end
               if (got.pool_empty !== want.pool_empty) begin
                  $error("pool_empty: expected %0d, got %0d", want.pool_empty, got.pool_empty);
                  errs++;
               end
               if (got.free_slots !== want.free_slots) begin
                  $error("free_slots: expected %0d, got %0d", want.free_slots, got.free_slots);
                  errs++;
               end
            end
         end
         outstanding <= pending_replies.size();
         fail_count  <= fail_count + errs;
      end
   end

endmodule

### tb/sv/tb.sv
// top of the allocator testbench: clock, reset, request and register stimulus, verdict
`timescale 1ns / 100ps

module tb;
   import fbfl_pkg::*;

   // no-progress limit, far above free latency plus worst stall and gap
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_REQUESTS = 150;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_opcode      = OP_STATUS;
   logic [OFF_W-1:0]     req_free_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic                 rsp_ok;
   logic [OFF_W-1:0]     rsp_block_offset;
   logic                 rsp_pool_full;
   logic                 rsp_pool_empty;
   logic [SLOT_W-1:0]    rsp_free_slots;
   logic                 csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_BLOCKS;
   logic [CSR_W-1:0]     csr_wdata       = '0;

   int fail_count;
   int outstanding;

   // register values as last written, used to aim free offsets at real blocks
   logic [BLK_W-1:0]  cur_blocks = BLOCKS_RESET;
   logic [DATA_W-1:0] cur_data   = DATA_RESET;

   // receiver stall state
   int stall_left = 0;
   int stall_pct  = 0;
   logic [7:0] rx_age = '0;

   int idle_cycles = 0;

   fixed_block_free_list_allocator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_block_offset (rsp_block_offset),
      .rsp_pool_full    (rsp_pool_full),
      .rsp_pool_empty   (rsp_pool_empty),
      .rsp_free_slots   (rsp_free_slots),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pool_reply_checker u_pool_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_block_offset (rsp_block_offset),
      .rsp_pool_full    (rsp_pool_full),
      .rsp_pool_empty   (rsp_pool_empty),
      .rsp_free_slots   (rsp_free_slots),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always #5 clock = ~clock;

   // receiver: ready or stalled, with stalls of random length whose
   // frequency is redrawn whenever rx_age wraps, from never to nearly always
   always @(posedge clock) begin
      rx_age <= rx_age + 1'b1;
      if (rx_age == 0) begin
         case ($urandom_range(3))
            0:       stall_pct <= 0;
            1:       stall_pct <= 10;
            2:       stall_pct <= 40;
            default: stall_pct <= 80;
         endcase
      end
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(99) < stall_pct)
            stall_left <= $urandom_range(1, 12);
      end
   end

   // watchdog: any accepted request or response counts as progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // data offset of block k under the current register values
   function automatic int unsigned block_addr(input int unsigned k);
      return k * (int'(cur_data) + HEADER_BYTES) + HEADER_BYTES;
   endfunction

   // present one request and hold it until the block takes it; returns on
   // the accepting edge so the next request can follow without a bubble
   task automatic send_request(input logic [OP_W-1:0] op, input int unsigned off);
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_free_offset <= OFF_W'(off);
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait for every response to come back; the checker's
   // count is registered, hence the first step
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // write both registers back to back while the block is idle; spare
   // upper bits of the block count write carry junk that must be ignored
   task automatic set_pool(input logic [BLK_W-1:0] blk, input logic [DATA_W-1:0] dat);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_BLOCKS;
      csr_wdata <= {4'($urandom), blk};
      @(posedge clock);
      csr_index <= CSR_DATA;
      csr_wdata <= dat;
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_blocks  = blk;
      cur_data    = dat;
   endtask

   initial begin
      int unsigned        nb;
      int unsigned        sel;
      int unsigned        off;
      int unsigned        alloc_pct;
      int unsigned        free_pct;
      int                 burst_left;
      bit                 gappy;
      logic [BLK_W-1:0]   blk;
      logic [DATA_W-1:0]  dat;
      logic [OP_W-1:0]    op;

      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset geometry first: 256 blocks of 60 bytes
      send_request(OP_STATUS, 0);
      send_request(OP_ALLOC, 21'h1FFFFF);     // offset field ignored on allocate
      send_request(OP_ALLOC, 0);
      send_request(OP_FREE, block_addr(1));
      send_request(OP_FREE, 0);               // below the header
      send_request(OP_FREE, 3);
      send_request(OP_FREE, 5);               // not on a block boundary
      send_request(OP_FREE, block_addr(256)); // one past the last block
      send_request(OP_FREE, 21'h1FFFFF);
      send_request(OP_FREE, block_addr(0));
      send_request(OP_FREE, block_addr(0));   // double free, count stays at zero
      send_request(OP_CLEAR, 0);

      // single block with no data bytes: stride is the header alone
      set_pool(9'd1, 13'd0);
      send_request(OP_ALLOC, 0);
      send_request(OP_ALLOC, 0);              // pool exhausted
      send_request(OP_FREE, block_addr(1));
      send_request(OP_FREE, block_addr(0));

      // empty pool reads as full from the start
      set_pool(9'd0, 13'd13);
      send_request(OP_STATUS, 0);
      send_request(OP_ALLOC, 0);
      send_request(OP_FREE, block_addr(0));

      // fill two blocks, then shrink to one: count above block count
      set_pool(9'd2, 13'd100);
      send_request(OP_CLEAR, 0);
      send_request(OP_ALLOC, 0);
      send_request(OP_ALLOC, 0);
      set_pool(9'd1, 13'd100);
      send_request(OP_ALLOC, 0);
      send_request(OP_FREE, block_addr(0));

      // block count above capacity saturates, largest stride
      set_pool(9'd511, 13'd8191);
      send_request(OP_ALLOC, 0);
      send_request(OP_FREE, block_addr(255));

      // random phases, each with its own geometry and operation mix; small
      // pools dominate so that full, exhausted and wrapped lists come often
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(9))
            0:       blk = 9'd0;
            1:       blk = 9'd256;
            2:       blk = 9'($urandom_range(257, 511));
            3:       blk = 9'($urandom_range(1, 256));
            default: blk = 9'($urandom_range(1, 12));
         endcase
         case ($urandom_range(5))
            0:       dat = 13'd0;
            1:       dat = 13'd8191;
            2:       dat = 13'($urandom_range(0, 8191));
            default: dat = 13'($urandom_range(1, 64));
         endcase
         set_pool(blk, dat);
         nb        = (cur_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_blocks);
         alloc_pct = $urandom_range(25, 75);
         free_pct  = (100 - alloc_pct) * 3 / 4;
         gappy     = ($urandom_range(3) != 0);

         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            // sender bursts, with idle gaps in most phases
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (gappy) begin
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 10)) @(posedge clock);
               end
            end
            burst_left--;

            sel = $urandom_range(99);
            if (sel < alloc_pct)
               op = OP_ALLOC;
            else if (sel < alloc_pct + free_pct)
               op = OP_FREE;
            else if (sel < alloc_pct + free_pct + 3)
               op = OP_CLEAR;
            else
               op = OP_STATUS;

            if (op == OP_FREE) begin
               // mostly real block offsets (one past the end now and then),
               // the rest misaligned, wild or at or near the header
               sel = $urandom_range(99);
               if (sel < 70)
                  off = block_addr($urandom_range(0, nb));
               else if (sel < 80)
                  off = block_addr($urandom_range(0, nb)) + $urandom_range(1, 3);
               else if (sel < 90)
                  off = $urandom_range(0, 21'h1FFFFF);
               else
                  off = $urandom_range(0, 7);
            end else begin
               off = $urandom;
            end
            send_request(op, off);
         end
      end

      // drain, then give any stray response time to show up
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### sim.f
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_ram.sv
rtl/core/fbfl_free_check.sv
rtl/core/fixed_block_free_list_allocator_core.sv
tb/sv/pool_reply_checker.sv
tb/sv/tb.sv
